// ----- hw/rtl/cspt_pkg.sv -----
// ----------------------------------------------------------------------------
// Capsule support point - shared definitions
// Widths, register indexes and sideband types of the support point pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cspt_pkg;

  localparam int unsigned QUAT_BITS  = 18;
  localparam int unsigned QUAT_FRAC  = 16;
  localparam int unsigned HALF_W     = 31;
  localparam int unsigned RAD_W      = 31;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned AXIS_W     = 22;
  localparam int unsigned BASE_W     = 40;
  localparam int unsigned WIDE_W     = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd5;

  localparam logic [QUAT_BITS-1:0] QUAT_ONE = 18'h10000;

  typedef struct packed {
    logic [2:0][BASE_W-1:0] base;
    logic [2:0][WIDE_W-1:0] num;
    logic [2:0]             neg;
    logic                   nz;
  } root_side_t;

  typedef struct packed {
    logic [2:0][BASE_W-1:0] base;
    logic [2:0]             neg;
    logic                   nz;
  } div_side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cspt_axis.sv -----
// ----------------------------------------------------------------------------
// Capsule axis
// Rotates (0,1,0) by the configured quaternion; two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cspt_axis (
  input  wire                                    clk_i,
  input  wire  [cspt_pkg::QUAT_BITS-1:0]         quat_w_i,
  input  wire  [cspt_pkg::QUAT_BITS-1:0]         quat_x_i,
  input  wire  [cspt_pkg::QUAT_BITS-1:0]         quat_y_i,
  input  wire  [cspt_pkg::QUAT_BITS-1:0]         quat_z_i,
  output logic [2:0][cspt_pkg::AXIS_W-1:0]       axis_o
);
  import cspt_pkg::*;

  localparam int unsigned PROD_W = 2 * QUAT_BITS;
  localparam int unsigned RAW_W  = PROD_W + 4;
  localparam logic signed [RAW_W-1:0] ONE_Q    = RAW_W'(1) << (2 * QUAT_FRAC);
  localparam logic signed [RAW_W-1:0] HALF_LSB = RAW_W'(1) << (QUAT_FRAC - 1);

  logic signed [PROD_W-1:0] xy_q, wz_q, xx_q, zz_q, yz_q, wx_q;
  logic signed [RAW_W-1:0]  raw_x, raw_y, raw_z;
  logic [2:0][AXIS_W-1:0]   axis_d, axis_q;

  always_ff @(posedge clk_i) begin
    xy_q <= $signed(quat_x_i) * $signed(quat_y_i);
    wz_q <= $signed(quat_w_i) * $signed(quat_z_i);
    xx_q <= $signed(quat_x_i) * $signed(quat_x_i);
    zz_q <= $signed(quat_z_i) * $signed(quat_z_i);
    yz_q <= $signed(quat_y_i) * $signed(quat_z_i);
    wx_q <= $signed(quat_w_i) * $signed(quat_x_i);
  end

  // round to nearest, ties up
  always_comb begin
    raw_x = ((RAW_W'(xy_q) - RAW_W'(wz_q)) <<< 1) + HALF_LSB;
    raw_y = ONE_Q - ((RAW_W'(xx_q) + RAW_W'(zz_q)) <<< 1) + HALF_LSB;
    raw_z = ((RAW_W'(yz_q) + RAW_W'(wx_q)) <<< 1) + HALF_LSB;
    axis_d[0] = raw_x[QUAT_FRAC +: AXIS_W];
    axis_d[1] = raw_y[QUAT_FRAC +: AXIS_W];
    axis_d[2] = raw_z[QUAT_FRAC +: AXIS_W];
  end

  always_ff @(posedge clk_i) begin
    axis_q <= axis_d;
  end

  assign axis_o = axis_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cspt_front.sv -----
// ----------------------------------------------------------------------------
// Capsule support point - front end
// Six stages: magnitudes, normalising shift, products, sums, endpoint base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cspt_front (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  en_i,
  input  wire                                  valid_i,
  input  wire  [2:0][cspt_pkg::COORD_W-1:0]    dir_i,
  input  wire  [2:0][cspt_pkg::COORD_W-1:0]    pos_i,
  input  wire  [2:0][cspt_pkg::AXIS_W-1:0]     axis_i,
  input  wire  [cspt_pkg::HALF_W-1:0]          half_i,
  input  wire  [cspt_pkg::RAD_W-1:0]           radius_i,
  output logic                                 valid_o,
  output logic [cspt_pkg::WIDE_W-1:0]          sum_o,
  output cspt_pkg::root_side_t                 side_o
);
  import cspt_pkg::*;

  localparam int unsigned DOT_W  = AXIS_W + COORD_W;
  localparam int unsigned DSUM_W = DOT_W + 2;
  localparam int unsigned OFFP_W = AXIS_W + HALF_W + 1;
  localparam int unsigned OFF_W  = OFFP_W - QUAT_FRAC;
  localparam int unsigned OFFN_W = OFF_W + 1;
  localparam int unsigned SH_W   = $clog2(COORD_W);
  localparam logic signed [OFFP_W-1:0] OFF_ROUND = OFFP_W'(1) << (QUAT_FRAC - 1);

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // stage 1
  logic [2:0][COORD_W-1:0] dir1_q, pos1_q;
  // stage 2
  logic [2:0][COORD_W-1:0] dir2_q, pos2_q, mag2_d, mag2_q;
  logic [2:0]              neg2_d, neg2_q;
  logic [COORD_W-1:0]      max01, max2_d, max2_q;
  // stage 3
  logic [SH_W-1:0]         shamt;
  logic [2:0][COORD_W-1:0] dir3_q, pos3_q, mag3_d, mag3_q;
  logic [2:0]              neg3_q;
  logic                    nz3_q;
  // stage 4
  logic [2:0][COORD_W-1:0] pos4_q;
  logic [2:0]              neg4_q;
  logic                    nz4_q;
  logic signed [DOT_W-1:0]  dotp4_d [3];
  logic signed [DOT_W-1:0]  dotp4_q [3];
  logic signed [OFFP_W-1:0] offp4_d [3];
  logic signed [OFFP_W-1:0] offp4_q [3];
  logic [2:0][WIDE_W-1:0]  sq4_d, sq4_q, num4_d, num4_q;
  // stage 5
  logic [2:0][COORD_W-1:0] pos5_q;
  logic [2:0]              neg5_q;
  logic                    nz5_q;
  logic [2:0][WIDE_W-1:0]  num5_q;
  logic [WIDE_W-1:0]       sum5_d, sum5_q;
  logic signed [DSUM_W-1:0] dot;
  logic signed [OFFP_W-1:0] rnd [3];
  logic signed [OFF_W-1:0]  off5_d [3];
  logic signed [OFF_W-1:0]  off5_q [3];
  logic                     dotneg5_d, dotneg5_q;
  // stage 6
  logic signed [OFFN_W-1:0] offn [3];
  root_side_t               side6_d, side6_q;
  logic [WIDE_W-1:0]        sum6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg2_d[i] = dir1_q[i][COORD_W-1];
      mag2_d[i] = neg2_d[i] ? (COORD_W'(0) - dir1_q[i]) : dir1_q[i];
    end
    max01  = (mag2_d[0] > mag2_d[1]) ? mag2_d[0] : mag2_d[1];
    max2_d = (max01 > mag2_d[2]) ? max01 : mag2_d[2];
  end

  // shift so the largest magnitude reaches bit 30
  always_comb begin
    shamt = '0;
    for (int b = 0; b < COORD_W - 2; b++) begin
      if (max2_q[b]) begin
        shamt = SH_W'(COORD_W - 2 - b);
      end
    end
    if (max2_q[COORD_W-1 -: 2] != 2'b00) begin
      shamt = '0;
    end
    for (int i = 0; i < 3; i++) begin
      mag3_d[i] = mag2_q[i] << shamt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dotp4_d[i] = $signed(axis_i[i]) * $signed(dir3_q[i]);
      offp4_d[i] = $signed(axis_i[i]) * $signed({1'b0, half_i});
      sq4_d[i]   = WIDE_W'(mag3_q[i]) * WIDE_W'(mag3_q[i]);
      num4_d[i]  = WIDE_W'(radius_i) * WIDE_W'(mag3_q[i]);
    end
  end

  always_comb begin
    dot    = '0;
    sum5_d = '0;
    for (int i = 0; i < 3; i++) begin
      dot       = dot + DSUM_W'(dotp4_q[i]);
      sum5_d    = sum5_d + sq4_q[i];
      rnd[i]    = offp4_q[i] + OFF_ROUND;
      off5_d[i] = rnd[i][QUAT_FRAC +: OFF_W];
    end
    dotneg5_d = dot[DSUM_W-1];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      offn[i] = dotneg5_q ? -(OFFN_W'(off5_q[i])) : OFFN_W'(off5_q[i]);
      side6_d.base[i] = BASE_W'($signed(pos5_q[i])) + BASE_W'(offn[i]);
    end
    side6_d.num = num5_q;
    side6_d.neg = neg5_q;
    side6_d.nz  = nz5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dir1_q    <= dir_i;
      pos1_q    <= pos_i;
      dir2_q    <= dir1_q;
      pos2_q    <= pos1_q;
      mag2_q    <= mag2_d;
      neg2_q    <= neg2_d;
      max2_q    <= max2_d;
      dir3_q    <= dir2_q;
      pos3_q    <= pos2_q;
      mag3_q    <= mag3_d;
      neg3_q    <= neg2_q;
      nz3_q     <= (max2_q != '0);
      pos4_q    <= pos3_q;
      neg4_q    <= neg3_q;
      nz4_q     <= nz3_q;
      dotp4_q   <= dotp4_d;
      offp4_q   <= offp4_d;
      sq4_q     <= sq4_d;
      num4_q    <= num4_d;
      pos5_q    <= pos4_q;
      neg5_q    <= neg4_q;
      nz5_q     <= nz4_q;
      num5_q    <= num4_q;
      sum5_q    <= sum5_d;
      off5_q    <= off5_d;
      dotneg5_q <= dotneg5_d;
      side6_q   <= side6_d;
      sum6_q    <= sum5_q;
    end
  end

  assign valid_o = v6_q;
  assign sum_o   = sum6_q;
  assign side_o  = side6_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cspt_root.sv -----
// ----------------------------------------------------------------------------
// Capsule support point - square root
// Integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cspt_root (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               en_i,
  input  wire                               valid_i,
  input  wire  [cspt_pkg::WIDE_W-1:0]       val_i,
  input  wire  cspt_pkg::root_side_t        side_i,
  output logic                              valid_o,
  output logic [cspt_pkg::ROOT_W-1:0]       root_o,
  output cspt_pkg::root_side_t              side_o
);
  import cspt_pkg::*;

  logic              vld_q  [ROOT_STEPS];
  logic [WIDE_W-1:0] rem_q  [ROOT_STEPS];
  logic [WIDE_W-1:0] res_q  [ROOT_STEPS];
  root_side_t        side_q [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [WIDE_W-1:0] STEP_BIT = WIDE_W'(1) << (WIDE_W - 2 - 2 * k);

    logic              vld_in;
    logic [WIDE_W-1:0] rem_in, res_in, trial, rem_d, res_d;
    root_side_t        side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = val_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = res_in + STEP_BIT;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + STEP_BIT;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_STEPS-1];
  assign root_o  = res_q[ROOT_STEPS-1][ROOT_W-1:0];
  assign side_o  = side_q[ROOT_STEPS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/cspt_div.sv -----
// ----------------------------------------------------------------------------
// Capsule support point - divider
// Three restoring dividers sharing one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cspt_div (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                en_i,
  input  wire                                valid_i,
  input  wire  [2:0][cspt_pkg::WIDE_W-1:0]   num_i,
  input  wire  [cspt_pkg::ROOT_W-1:0]        den_i,
  input  wire  cspt_pkg::div_side_t          side_i,
  output logic                               valid_o,
  output logic [2:0][cspt_pkg::ROOT_W-1:0]   quo_o,
  output cspt_pkg::div_side_t                side_o
);
  import cspt_pkg::*;

  logic                   vld_q  [DIV_STEPS];
  logic [ROOT_W-1:0]      den_q  [DIV_STEPS];
  logic [2:0][ROOT_W-1:0] rem_q  [DIV_STEPS];
  logic [2:0][ROOT_W-1:0] lo_q   [DIV_STEPS];
  div_side_t              side_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                   vld_in;
    logic [ROOT_W-1:0]      den_in;
    logic [2:0][ROOT_W-1:0] rem_in, lo_in, rem_d, lo_d;
    logic [ROOT_W:0]        part [3];
    logic [ROOT_W:0]        diff [3];
    logic [2:0]             ge;
    div_side_t              side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = num_i[i][WIDE_W-1 -: ROOT_W];
        assign lo_in[i]  = num_i[i][ROOT_W-1:0];
      end
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign lo_in   = lo_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        part[i]  = {rem_in[i], lo_in[i][ROOT_W-1]};
        diff[i]  = part[i] - {1'b0, den_in};
        ge[i]    = (part[i] >= {1'b0, den_in});
        rem_d[i] = ge[i] ? diff[i][ROOT_W-1:0] : part[i][ROOT_W-1:0];
        lo_d[i]  = {lo_in[i][ROOT_W-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        rem_q[k]  <= rem_d;
        lo_q[k]   <= lo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign quo_o   = lo_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/capsule_support_point.sv -----
// Throughput: one transaction per cycle while the skid register is empty;
//   depth set by the 32-stage square root and the 32-stage divider
//   pipelines.
// Reset: clears all valid flags; quat_w = 1.0, other registers zero.
// A write reaches the rotated axis via the product and axis registers.
// ----------------------------------------------------------------------------
// Capsule support point
// Farthest capsule surface point along a query direction, saturated Q16.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module capsule_support_point (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // query_x, query_y, query_z, pos_x, pos_y, pos_z
  input  wire  [6*cspt_pkg::COORD_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // far_x, far_y, far_z
  output logic [3*cspt_pkg::COORD_W-1:0]      m_axis_tdata,
  input  wire                                 cfg_we_i,
  input  wire  [cspt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [cspt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cspt_pkg::*;

  localparam int unsigned SUM_W = BASE_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (COORD_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << (COORD_W - 1));

  logic [QUAT_BITS-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
  logic [HALF_W-1:0]    half_q;
  logic [RAD_W-1:0]     radius_q;

  logic [2:0][COORD_W-1:0] dir, pos;
  logic [2:0][AXIS_W-1:0]  axis;

  logic                    pipe_en;
  logic                    front_vld;
  logic [WIDE_W-1:0]       front_sum;
  root_side_t              front_side;
  logic                    root_vld;
  logic [ROOT_W-1:0]       root_len;
  root_side_t              root_side;

  logic                    prep_vld_q;
  logic [2:0][WIDE_W-1:0]  prep_num_d, prep_num_q;
  logic [ROOT_W-1:0]       prep_den_q;
  div_side_t               prep_side_d, prep_side_q;

  logic                    div_vld;
  logic [2:0][ROOT_W-1:0]  div_quo;
  div_side_t               div_side;

  logic signed [COORD_W:0] rad [3];
  logic signed [SUM_W-1:0] total [3];
  logic [3*COORD_W-1:0]    fin_data;

  logic                    new_vld, out_free;
  logic                    out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  logic [3*COORD_W-1:0]    out_data_q, skid_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_w_q <= QUAT_ONE;
      quat_x_q <= '0;
      quat_y_q <= '0;
      quat_z_q <= '0;
      half_q   <= '0;
      radius_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUAT_W:   quat_w_q <= cfg_data_i[QUAT_BITS-1:0];
        REG_QUAT_X:   quat_x_q <= cfg_data_i[QUAT_BITS-1:0];
        REG_QUAT_Y:   quat_y_q <= cfg_data_i[QUAT_BITS-1:0];
        REG_QUAT_Z:   quat_z_q <= cfg_data_i[QUAT_BITS-1:0];
        REG_HALF_LEN: half_q   <= cfg_data_i[HALF_W-1:0];
        REG_RADIUS:   radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  cspt_axis u_axis (
    .clk_i    (clk_i),
    .quat_w_i (quat_w_q),
    .quat_x_i (quat_x_q),
    .quat_y_i (quat_y_q),
    .quat_z_i (quat_z_q),
    .axis_o   (axis)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = s_axis_tdata[i*COORD_W +: COORD_W];
      pos[i] = s_axis_tdata[(i+3)*COORD_W +: COORD_W];
    end
  end

  assign pipe_en       = !skid_vld_q;
  assign s_axis_tready = pipe_en;

  cspt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (s_axis_tvalid),
    .dir_i    (dir),
    .pos_i    (pos),
    .axis_i   (axis),
    .half_i   (half_q),
    .radius_i (radius_q),
    .valid_o  (front_vld),
    .sum_o    (front_sum),
    .side_o   (front_side)
  );

  cspt_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (front_vld),
    .val_i   (front_sum),
    .side_i  (front_side),
    .valid_o (root_vld),
    .root_o  (root_len),
    .side_o  (root_side)
  );

  // add half the divisor for round-to-nearest
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prep_num_d[i] = root_side.num[i] + WIDE_W'(root_len >> 1);
    end
    prep_side_d.base = root_side.base;
    prep_side_d.neg  = root_side.neg;
    prep_side_d.nz   = root_side.nz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (pipe_en) begin
      prep_vld_q <= root_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prep_num_q  <= prep_num_d;
      prep_den_q  <= root_len;
      prep_side_q <= prep_side_d;
    end
  end

  cspt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (prep_vld_q),
    .num_i   (prep_num_q),
    .den_i   (prep_den_q),
    .side_i  (prep_side_q),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!div_side.nz) begin
        rad[i] = '0;
      end else if (div_side.neg[i]) begin
        rad[i] = -$signed({1'b0, div_quo[i]});
      end else begin
        rad[i] = $signed({1'b0, div_quo[i]});
      end
      total[i] = SUM_W'($signed(div_side.base[i])) + SUM_W'(rad[i]);
      if (total[i] > SAT_HI) begin
        fin_data[i*COORD_W +: COORD_W] = SAT_HI[COORD_W-1:0];
      end else if (total[i] < SAT_LO) begin
        fin_data[i*COORD_W +: COORD_W] = SAT_LO[COORD_W-1:0];
      end else begin
        fin_data[i*COORD_W +: COORD_W] = total[i][COORD_W-1:0];
      end
    end
  end

  // output register with skid stage
  assign new_vld  = div_vld & pipe_en;
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = new_vld;
      end
    end else if (new_vld) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_vld_q ? skid_data_q : fin_data;
    end
    if (!out_free && new_vld) begin
      skid_data_q <= fin_data;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
